@@ sv/mscc_pkg.sv @@
package mscc_pkg;

    // Item field widths
    localparam int SEG_W   = 11;
    localparam int CNT_W   = 11;
    localparam int ENTRY_W = CNT_W + 1;
    localparam int NUM_SEG = 3;

    typedef logic [SEG_W-1:0]   t_seg;
    typedef logic [CNT_W-1:0]   t_count;
    // Table entry: top bit flags an unreachable length, the rest is the piece count
    typedef logic [ENTRY_W-1:0] t_entry;

    localparam t_entry UNREACH = t_entry'(1) << CNT_W;

    // Fold one look-back entry into the running best
    function automatic t_entry look_back(input t_entry cur, input logic use_it,
                                         input t_entry prev);
        t_entry cand;
        begin
            cand = t_entry'(prev[CNT_W-1:0]) + t_entry'(1);
            if (!use_it || prev[CNT_W]) begin
                look_back = cur;
            end else if (cur[CNT_W] || (cand > cur)) begin
                look_back = {1'b0, cand[CNT_W-1:0]};
            end else begin
                look_back = cur;
            end
        end
    endfunction

endpackage

@@ sv/max_segment_cut_count.sv @@
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+---------------------------------
// request   | in        | start high while busy low  | i_rod_length, i_seg_a/b/c
// result    | out       | o_valid, one cycle          | o_max_pieces
//
// A request fills the table for lengths 1..rod_length, one entry at a time in two read
// phases: the table is kept in two copies with one read port each, so the three
// look-backs of an entry take two reads. A rod of length 0 or longer than MAX_LEN
// answers 0 in the cycle after accept. Reset (synchronous, active low) clears control
// only; the table stays undefined and is always written before it is read. The
// receiver cannot stall.
module max_segment_cut_count #(
    parameter int MAX_LEN = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [10:0]           i_rod_length,
    input  logic [10:0]           i_seg_a,
    input  logic [10:0]           i_seg_b,
    input  logic [10:0]           i_seg_c,
    output logic                  o_valid,
    output logic [10:0]           o_max_pieces
);
    import mscc_pkg::*;

    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int CW     = ((LW > SEG_W) ? LW : SEG_W) + 1;
    localparam int NUM_RD = 2;

    // Read phases of one entry: first and second look-back, then the third
    localparam logic PH_AB = 1'b0;
    localparam logic PH_C  = 1'b1;

    // Request registers
    logic                     r_issue;
    logic                     r_ph;
    logic [LW-1:0]            r_i;
    logic [LW-1:0]            r_n;
    t_seg [NUM_SEG-1:0]       r_seg;

    // Compare stage registers
    logic                     r_c_v;
    logic                     r_c_ph;
    logic [LW-1:0]            r_c_i;
    logic [NUM_SEG-1:0]       r_skip;
    logic [NUM_SEG-1:0]       r_zero;
    logic [NUM_SEG-1:0]       r_fwd;
    t_entry                   r_part;
    t_entry                   r_last_e;

    // Result registers
    logic                     r_out_v;
    t_count                   r_out;

    logic [NUM_SEG-1:0]       skip;
    logic [NUM_SEG-1:0]       zero;
    logic [NUM_SEG-1:0]       fwd;
    logic [NUM_SEG-1:0][LW-1:0] lb_addr;
    logic [NUM_RD-1:0][LW-1:0]  rd_addr;
    t_entry [NUM_RD-1:0]      rd_data;
    t_entry [NUM_SEG-1:0]     prev;
    t_entry                   e_part;
    t_entry                   e_best;
    logic                     tab_we;
    logic                     accept;
    logic                     too_long;

    assign busy     = r_issue | r_c_v;
    assign accept   = start & ~busy;
    assign too_long = (CW'(i_rod_length) > CW'(MAX_LEN)) || (i_rod_length == '0);
    assign tab_we   = r_c_v & (r_c_ph == PH_C);

    // Look-back addresses for the entry being issued
    always_comb begin
        for (int k = 0; k < NUM_SEG; k++) begin
            logic [CW-1:0] ext_seg;
            logic [CW-1:0] ext_i;
            logic [CW-1:0] diff;
            ext_seg    = CW'(r_seg[k]);
            ext_i      = CW'(r_i);
            diff       = ext_i - ext_seg;
            skip[k]    = (r_seg[k] == '0) || (ext_seg > ext_i);
            zero[k]    = (ext_seg == ext_i);
            fwd[k]     = (r_seg[k] == t_seg'(1));
            lb_addr[k] = diff[LW-1:0];
        end
    end

    // Read the first two look-backs together, the third in the PH_C phase
    assign rd_addr[0] = (r_ph == PH_C) ? lb_addr[2] : lb_addr[0];
    assign rd_addr[1] = lb_addr[1];

    // Two table copies, both written with the same entry
    for (genvar g = 0; g < NUM_RD; g++) begin : g_tab
        mscc_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (MAX_LEN + 1)
        ) u_tab (
            .i_clk   (i_clk),
            .i_we    (tab_we),
            .i_waddr (r_c_i),
            .i_wdata (e_best),
            .i_raddr (rd_addr[g]),
            .o_rdata (rd_data[g])
        );
    end

    // Pick each look-back source: length zero, forwarded last entry, or the table
    always_comb begin
        for (int k = 0; k < NUM_SEG; k++) begin
            priority if (r_zero[k]) begin
                prev[k] = '0;
            end else if (r_fwd[k]) begin
                prev[k] = r_last_e;
            end else if (k == 1) begin
                prev[k] = rd_data[1];
            end else begin
                prev[k] = rd_data[0];
            end
        end
    end

    // Best of the look-backs plus one, folded over the two read phases
    always_comb begin
        e_part = look_back(UNREACH, ~r_skip[0], prev[0]);
        e_part = look_back(e_part, ~r_skip[1], prev[1]);
        e_best = look_back(r_part, ~r_skip[2], prev[2]);
    end

    // Issue entries, advance the compare stage, and drop the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_c_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            r_c_v   <= r_issue;
            if (accept) begin
                if (too_long) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_issue <= 1'b1;
                end
            end else if (r_issue && (r_ph == PH_C) && (r_i == r_n)) begin
                r_issue <= 1'b0;
            end
            if (tab_we && (r_c_i == r_n)) begin
                r_out_v <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n      <= LW'(i_rod_length);
            r_i      <= LW'(1);
            r_ph     <= PH_AB;
            r_seg[0] <= i_seg_a;
            r_seg[1] <= i_seg_b;
            r_seg[2] <= i_seg_c;
            r_out    <= '0;
        end else if (r_issue) begin
            if (r_ph == PH_C) begin
                r_ph <= PH_AB;
                r_i  <= r_i + LW'(1);
            end else begin
                r_ph <= PH_C;
            end
        end
        r_c_i  <= r_i;
        r_c_ph <= r_ph;
        r_skip <= skip;
        r_zero <= zero;
        r_fwd  <= fwd & ~zero;
        if (r_c_v) begin
            if (r_c_ph == PH_AB) begin
                r_part <= e_part;
            end else begin
                r_last_e <= e_best;
                if (r_c_i == r_n) begin
                    r_out <= e_best[CNT_W] ? '0 : e_best[CNT_W-1:0];
                end
            end
        end
    end

    assign o_valid      = r_out_v;
    assign o_max_pieces = r_out;

endmodule

@@ sv/mscc_ram.sv @@
module mscc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ test/tb_max_segment_cut_count.sv @@
module tb_max_segment_cut_count;
    timeunit 1ns;
    timeprecision 1ps;

    import mscc_pkg::*;

    localparam int MAX_LEN     = 1024;
    localparam int RESET_CYC   = 12;
    localparam int RAND_ITEMS  = 500;
    localparam int DRAIN_EVERY = 125;
    localparam int TAIL_CYC    = 8;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int NUM_ROWS    = 18;

    // One directed request; known marks a result that is typed in by hand
    typedef struct {
        t_seg   rod;
        t_seg   sa;
        t_seg   sb;
        t_seg   sc;
        t_count pieces;
        bit     known;
    } t_cut_row;

    // Result still owed by the block, with its request kept for reporting
    typedef struct {
        t_seg   rod;
        t_seg   sa;
        t_seg   sb;
        t_seg   sc;
        t_count pieces;
    } t_pieces_due;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_seg   i_rod_length = '0;
    t_seg   i_seg_a = '0;
    t_seg   i_seg_b = '0;
    t_seg   i_seg_c = '0;
    logic   o_valid;
    t_count o_max_pieces;

    t_pieces_due pieces_due[$];
    t_pieces_due got_due;

    int cycle_count = 0;
    int err_count   = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_rejected  = 0;
    int n_zero      = 0;
    int n_long      = 0;
    int burst_left  = 0;

    // Directed requests: extremes, rejected rods, zero and oversize segments
    t_cut_row cut_rows [NUM_ROWS] = '{
        '{11'd0,    11'd1,    11'd1,    11'd1,    11'd0,    1'b1},
        '{11'd1024, 11'd1,    11'd1,    11'd1,    11'd1024, 1'b1},
        '{11'd1025, 11'd1,    11'd1,    11'd1,    11'd0,    1'b1},
        '{11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd0,    1'b1},
        '{11'd1024, 11'd0,    11'd0,    11'd0,    11'd0,    1'b1},
        '{11'd5,    11'd0,    11'd0,    11'd5,    11'd1,    1'b1},
        '{11'd7,    11'd8,    11'd9,    11'd10,   11'd0,    1'b1},
        '{11'd1024, 11'd1024, 11'd2047, 11'd0,    11'd1,    1'b1},
        '{11'd7,    11'd2,    11'd3,    11'd5,    11'd0,    1'b0},
        '{11'd11,   11'd2,    11'd2,    11'd2,    11'd0,    1'b0},
        '{11'd4,    11'd5,    11'd3,    11'd2,    11'd0,    1'b0},
        '{11'd1023, 11'd1024, 11'd1024, 11'd1024, 11'd0,    1'b1},
        '{11'd1024, 11'd2,    11'd0,    11'd0,    11'd0,    1'b0},
        '{11'd1,    11'd1,    11'd2047, 11'd2047, 11'd1,    1'b1},
        '{11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    1'b1},
        '{11'd13,   11'd13,   11'd13,   11'd13,   11'd1,    1'b1},
        '{11'd2047, 11'd1,    11'd1,    11'd1,    11'd0,    1'b1},
        '{11'd1024, 11'd1023, 11'd1,    11'd0,    11'd0,    1'b0}
    };

    max_segment_cut_count #(
        .MAX_LEN(MAX_LEN)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_rod_length(i_rod_length),
        .i_seg_a     (i_seg_a),
        .i_seg_b     (i_seg_b),
        .i_seg_c     (i_seg_c),
        .o_valid     (o_valid),
        .o_max_pieces(o_max_pieces)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Fill the cut table bottom up and read the entry for the full rod
    function automatic t_count predict_max_pieces(input t_seg rod, input t_seg sa,
                                                  input t_seg sb, input t_seg sc);
        t_entry cut_best [0:MAX_LEN];
        t_seg   segs [NUM_SEG];
        t_entry cur;
        t_entry prev;
        t_entry cand;
        begin
            if (int'(rod) > MAX_LEN) return '0;
            segs[0] = sa;
            segs[1] = sb;
            segs[2] = sc;
            cut_best[0] = '0;
            for (int len = 1; len <= int'(rod); len++) begin
                cur = UNREACH;
                for (int k = 0; k < NUM_SEG; k++) begin
                    if (segs[k] != '0 && int'(segs[k]) <= len) begin
                        prev = cut_best[len - int'(segs[k])];
                        if (!prev[CNT_W]) begin
                            cand = t_entry'(prev[CNT_W-1:0]) + t_entry'(1);
                            if (cur[CNT_W] || cand > cur) cur = {1'b0, cand[CNT_W-1:0]};
                        end
                    end
                end
                cut_best[len] = cur;
            end
            cur = cut_best[int'(rod)];
            return cur[CNT_W] ? t_count'(0) : cur[CNT_W-1:0];
        end
    endfunction

    // Segment lengths: mostly short, some zero, some anywhere in the field
    function automatic t_seg pick_seg();
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (r < 75) return t_seg'($urandom_range(1, 12));
            if (r < 85) return t_seg'($urandom_range(13, 64));
            if (r < 92) return '0;
            return t_seg'($urandom_range(0, 2047));
        end
    endfunction

    // Rod lengths: mostly short, a few long, exact maximum and rejected ones
    function automatic t_seg pick_rod();
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (r < 70) return t_seg'($urandom_range(0, 48));
            if (r < 85) return t_seg'($urandom_range(49, 1024));
            if (r < 90) return t_seg'(MAX_LEN);
            if (r < 95) return t_seg'($urandom_range(1025, 2047));
            return '0;
        end
    endfunction

    // Present one item, hold it until accepted, then keep the burst or idle
    task automatic send_cut(input t_seg rod, input t_seg sa, input t_seg sb,
                            input t_seg sc, input t_count typed, input bit known);
        t_pieces_due due;
        begin
            start        <= 1'b1;
            i_rod_length <= rod;
            i_seg_a      <= sa;
            i_seg_b      <= sb;
            i_seg_c      <= sc;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            due.rod    = rod;
            due.sa     = sa;
            due.sb     = sb;
            due.sc     = sc;
            due.pieces = known ? typed : predict_max_pieces(rod, sa, sb, sc);
            pieces_due.push_back(due);
            n_sent++;
            if (int'(rod) > MAX_LEN) n_rejected++;
            else if (rod == '0) n_zero++;
            else if (int'(rod) >= MAX_LEN / 2) n_long++;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                start      <= 1'b0;
                burst_left = $urandom_range(0, 7);
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain_results();
        begin
            start <= 1'b0;
            burst_left = 0;
            @(posedge i_clk);
            while (pieces_due.size() != 0) @(posedge i_clk);
        end
    endtask

    // Compare each result with the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pieces_due.size() == 0) begin
                err_count++;
                $display("%0t: result with none owed: expected nothing, actual %0d",
                         $time, o_max_pieces);
            end else begin
                got_due = pieces_due.pop_front();
                n_checked++;
                if (o_max_pieces !== got_due.pieces) begin
                    err_count++;
                    $display("%0t: max_pieces rod=%0d segs=%0d/%0d/%0d: expected %0d, actual %0d",
                             $time, got_due.rod, got_due.sa, got_due.sb, got_due.sc,
                             got_due.pieces, o_max_pieces);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results owed",
                     $time, cycle_count, pieces_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int row = 0; row < NUM_ROWS; row++) begin
            send_cut(cut_rows[row].rod, cut_rows[row].sa, cut_rows[row].sb,
                     cut_rows[row].sc, cut_rows[row].pieces, cut_rows[row].known);
        end
        drain_results();

        // Random requests, pausing now and then until the block is empty
        for (int item = 0; item < RAND_ITEMS; item++) begin
            send_cut(pick_rod(), pick_seg(), pick_seg(), pick_seg(), '0, 1'b0);
            if (item % DRAIN_EVERY == DRAIN_EVERY - 1) drain_results();
        end
        start <= 1'b0;

        // Let the last results land, then a short tail
        @(posedge i_clk);
        while (pieces_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed), compared %0d results in %0d cycles",
                 n_sent, NUM_ROWS, n_checked, cycle_count);
        $display("Rods: %0d rejected, %0d of length zero, %0d of half the maximum or more",
                 n_rejected, n_zero, n_long);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ max_segment_cut_count.f @@
sv/mscc_pkg.sv
sv/mscc_ram.sv
sv/max_segment_cut_count.sv
test/tb_max_segment_cut_count.sv
